### hdl/thd_pkg.sv
// Shared types, codes and helper functions for the tap-and-hold detector.
package thd_pkg;

	// Coordinate and countdown widths
	localparam int COORD_BITS = 12;
	localparam int TICK_BITS  = 16;
	localparam int CFG_BITS   = 16;
	localparam int RADIUS_BITS = 10;
	localparam int R2_BITS    = 2 * RADIUS_BITS;
	localparam int DIST_BITS  = 2 * COORD_BITS + 1;

	localparam logic [31:0] TICK_MAX = (TICK_BITS >= 32) ? 32'hFFFF_FFFF :
		((32'd1 << TICK_BITS) - 32'd1);

	typedef logic [COORD_BITS-1:0]  coord_t;
	typedef logic [TICK_BITS-1:0]   tick_t;
	typedef logic [CFG_BITS-1:0]    cfg_data_t;
	typedef logic [RADIUS_BITS-1:0] radius_t;
	typedef logic [R2_BITS-1:0]     r2_t;

	// Configuration register indexes
	typedef logic [1:0] cfg_index_t;
	localparam cfg_index_t REG_TAP_RADIUS    = 2'd0;
	localparam cfg_index_t REG_TRIGGER_TICKS = 2'd1;
	localparam cfg_index_t REG_HOLD_TICKS    = 2'd2;

	// Reset values of the registers
	localparam radius_t   TAP_RADIUS_RST    = 10'd16;
	localparam cfg_data_t TRIGGER_TICKS_RST = 16'd150;
	localparam cfg_data_t HOLD_TICKS_RST    = 16'd500;

	// Event kinds
	typedef enum logic [1:0] {
		CMD_PRESS   = 2'd0,
		CMD_MOVE    = 2'd1,
		CMD_RELEASE = 2'd2,
		CMD_TICK    = 2'd3
	} cmd_t;

	// Result codes
	typedef enum logic [2:0] {
		V_IGNORE  = 3'd0,
		V_MAYBE   = 3'd1,
		V_CANCEL  = 3'd2,
		V_TRIGGER = 3'd3,
		V_FINISH  = 3'd4
	} verdict_t;

	// Gesture phase
	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_WAITING = 2'd1,
		PH_STARTED = 2'd2
	} phase_t;

	// One input word as held in the input register
	typedef struct packed {
		cmd_t   cmd;
		logic   left;
		coord_t x;
		coord_t y;
	} item_t;

	// Derived configuration handed to the datapath
	typedef struct packed {
		r2_t   r2;
		tick_t trigger_load;
		tick_t rest_load;
	} cfg_t;

	// Clamp a tick count to one at the bottom and to the counter range at the top
	function automatic tick_t load_ticks(input logic [31:0] v);
		tick_t r;
		if (v == 32'd0) begin
			r = tick_t'(1);
		end else if (v > TICK_MAX) begin
			r = tick_t'(TICK_MAX);
		end else begin
			r = tick_t'(v);
		end
		return r;
	endfunction

	// Ticks between trigger and finish, at least one
	function automatic tick_t rest_ticks(input cfg_data_t trig, input cfg_data_t hold);
		logic [31:0] d;
		if (hold > trig) begin
			d = 32'(hold - trig);
		end else begin
			d = 32'd1;
		end
		return load_ticks(d);
	endfunction

endpackage

### hdl/tap_and_hold_detector_core.sv
// Top level of the tap-and-hold detector: input register, state update, result register.
//
// Long-press detector: each accepted word (press, move, release or tick) yields exactly one
// result word carrying a verdict and the recorded press point. One word is accepted per clock
// cycle while in_stall is low; a word is evaluated while it is held in the input register,
// and its result is captured in the result register once that register is empty or its
// word is being taken. Throughput is set by the single state-update stage, whose path
// is the squared-distance compare of two 12x12 products against the squared radius; the
// squared radius and both countdown loads are computed when configuration is written. The
// configuration port is always ready and must only be written while no words are in flight.
module tap_and_hold_detector_core
	import thd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	// input channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] cmd,
	input  logic       left_button,
	input  coord_t     x_pos,
	input  coord_t     y_pos,
	// result channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] verdict,
	output coord_t     hot_x,
	output coord_t     hot_y,
	// configuration channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  cfg_index_t cfg_index,
	input  cfg_data_t  cfg_data
);

	logic     valid_s1;
	item_t    item_s1;
	logic     valid_s2;
	verdict_t verdict_s2;
	coord_t   hot_x_s2;
	coord_t   hot_y_s2;
	logic     advance;
	logic     step;
	logic     take;
	cfg_t     cfg;
	verdict_t verdict_c;
	coord_t   hot_x_c;
	coord_t   hot_y_c;

	// Handshake control
	assign advance   = !valid_s2 || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign take      = in_valid && !in_stall;
	assign step      = valid_s1 && advance;
	assign cfg_ready = 1'b1;

	thd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	thd_fsm u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.item    (item_s1),
		.cfg     (cfg),
		.verdict (verdict_c),
		.hot_x   (hot_x_c),
		.hot_y   (hot_y_c)
	);

	// Input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Capture the input word
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.cmd  <= cmd_t'(cmd);
			item_s1.left <= left_button;
			item_s1.x    <= x_pos;
			item_s1.y    <= y_pos;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	// Hold the result word until it is taken
	always_ff @(posedge clk) begin
		if (step) begin
			verdict_s2 <= verdict_c;
			hot_x_s2   <= hot_x_c;
			hot_y_s2   <= hot_y_c;
		end
	end

	assign out_valid = valid_s2;
	assign verdict   = verdict_s2;
	assign hot_x     = hot_x_s2;
	assign hot_y     = hot_y_s2;

endmodule

### hdl/thd_cfg_regs.sv
// Configuration registers with precomputed squared radius and countdown loads.
module thd_cfg_regs
	import thd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  cfg_index_t wr_index,
	input  cfg_data_t  wr_data,
	output cfg_t       cfg
);

	cfg_data_t trigger_q;
	cfg_data_t hold_q;
	r2_t       r2_q;
	tick_t     trigger_load_q;
	tick_t     rest_load_q;
	radius_t   wr_radius;

	assign wr_radius = wr_data[RADIUS_BITS-1:0];

	// Hold raw tick counts and derived values; refresh derived values on each write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trigger_q      <= TRIGGER_TICKS_RST;
			hold_q         <= HOLD_TICKS_RST;
			r2_q           <= r2_t'(TAP_RADIUS_RST) * r2_t'(TAP_RADIUS_RST);
			trigger_load_q <= load_ticks(32'(TRIGGER_TICKS_RST));
			rest_load_q    <= rest_ticks(TRIGGER_TICKS_RST, HOLD_TICKS_RST);
		end else if (wr_en) begin
			case (wr_index)
				REG_TAP_RADIUS: begin
					r2_q <= r2_t'(wr_radius) * r2_t'(wr_radius);
				end
				REG_TRIGGER_TICKS: begin
					trigger_q      <= wr_data;
					trigger_load_q <= load_ticks(32'(wr_data));
					rest_load_q    <= rest_ticks(wr_data, hold_q);
				end
				REG_HOLD_TICKS: begin
					hold_q      <= wr_data;
					rest_load_q <= rest_ticks(trigger_q, wr_data);
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.r2           = r2_q;
	assign cfg.trigger_load = trigger_load_q;
	assign cfg.rest_load    = rest_load_q;

endmodule

### hdl/thd_dist.sv
// Squared travel distance check against the squared tap radius.
module thd_dist
	import thd_pkg::*;
(
	input  coord_t x,
	input  coord_t y,
	input  coord_t start_x,
	input  coord_t start_y,
	input  r2_t    r2,
	output logic   too_far
);

	coord_t                  dx;
	coord_t                  dy;
	logic [2*COORD_BITS-1:0] dx2;
	logic [2*COORD_BITS-1:0] dy2;
	logic [DIST_BITS-1:0]    d2;

	// Absolute differences
	assign dx = (x >= start_x) ? (x - start_x) : (start_x - x);
	assign dy = (y >= start_y) ? (y - start_y) : (start_y - y);

	// Square, sum and compare
	assign dx2     = (2*COORD_BITS)'(dx) * (2*COORD_BITS)'(dx);
	assign dy2     = (2*COORD_BITS)'(dy) * (2*COORD_BITS)'(dy);
	assign d2      = DIST_BITS'(dx2) + DIST_BITS'(dy2);
	assign too_far = d2 > DIST_BITS'(r2);

endmodule

### hdl/thd_fsm.sv
// Gesture phase, countdown and press point, updated once per word.
module thd_fsm
	import thd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  item_t    item,
	input  cfg_t     cfg,
	output verdict_t verdict,
	output coord_t   hot_x,
	output coord_t   hot_y
);

	phase_t phase_q, phase_d;
	tick_t  cnt_q, cnt_d;
	coord_t sx_q, sx_d;
	coord_t sy_q, sy_d;
	tick_t  cnt_dec;
	logic   running;
	logic   expire;
	logic   too_far;

	thd_dist u_dist (
		.x       (item.x),
		.y       (item.y),
		.start_x (sx_q),
		.start_y (sy_q),
		.r2      (cfg.r2),
		.too_far (too_far)
	);

	assign running = cnt_q != '0;
	assign cnt_dec = cnt_q - tick_t'(1);
	assign expire  = running && (cnt_dec == '0);

	// Next state
	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		sx_d    = sx_q;
		sy_d    = sy_q;
		case (item.cmd)
			CMD_PRESS: begin
				if (item.left) begin
					sx_d    = item.x;
					sy_d    = item.y;
					cnt_d   = cfg.trigger_load;
					phase_d = PH_WAITING;
				end
			end
			CMD_MOVE: begin
				if (item.left && running && too_far) begin
					cnt_d   = '0;
					phase_d = PH_IDLE;
				end
			end
			CMD_RELEASE: begin
				if (item.left && running) begin
					cnt_d   = '0;
					phase_d = PH_IDLE;
				end
			end
			CMD_TICK: begin
				if (running) begin
					cnt_d = cnt_dec;
					if (expire) begin
						if (phase_q == PH_WAITING) begin
							cnt_d   = cfg.rest_load;
							phase_d = PH_STARTED;
						end else begin
							phase_d = PH_IDLE;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Result code
	always_comb begin
		verdict = V_IGNORE;
		case (item.cmd)
			CMD_PRESS: begin
				if (item.left) begin
					verdict = V_MAYBE;
				end
			end
			CMD_MOVE: begin
				if (item.left && running && too_far) begin
					verdict = V_CANCEL;
				end
			end
			CMD_RELEASE: begin
				if (item.left && running) begin
					verdict = V_CANCEL;
				end
			end
			CMD_TICK: begin
				if (expire) begin
					if (phase_q == PH_WAITING) begin
						verdict = V_TRIGGER;
					end else if (phase_q == PH_STARTED) begin
						verdict = V_FINISH;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign hot_x = sx_d;
	assign hot_y = sy_d;

	// Advance state on each word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			sx_q    <= '0;
			sy_q    <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			sx_q    <= sx_d;
			sy_q    <= sy_d;
		end
	end

endmodule

### verif/tap_and_hold_checker.sv
// Checker for the tap-and-hold detector: predicts each result word and compares it on arrival.
`timescale 1ns / 100ps

module tap_and_hold_checker
	import thd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [1:0] cmd,
	input  logic       left_button,
	input  coord_t     x_pos,
	input  coord_t     y_pos,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [2:0] verdict,
	input  coord_t     hot_x,
	input  coord_t     hot_y,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  cfg_index_t cfg_index,
	input  cfg_data_t  cfg_data,
	output int         mismatches,
	output int         outstanding
);

	typedef struct packed {
		verdict_t verdict;
		coord_t   hot_x;
		coord_t   hot_y;
	} gesture_result_t;

	// Shadow copy of the registers
	radius_t   radius;
	cfg_data_t trigger_cfg;
	cfg_data_t hold_cfg;

	// Shadow copy of the gesture state
	phase_t gesture_phase;
	tick_t  ticks_left;
	coord_t anchor_x;
	coord_t anchor_y;

	gesture_result_t predicted_results[$];

	// Apply one event to the shadow state and return the result word it should produce
	function automatic gesture_result_t classify_event(cmd_t kind, logic left, coord_t x,
			coord_t y);
		gesture_result_t r;
		int unsigned dx;
		int unsigned dy;
		int unsigned r2;
		r.verdict = V_IGNORE;
		case (kind)
			CMD_PRESS: begin
				if (left) begin
					anchor_x = x;
					anchor_y = y;
					ticks_left = (trigger_cfg == '0) ? tick_t'(1) : tick_t'(trigger_cfg);
					gesture_phase = PH_WAITING;
					r.verdict = V_MAYBE;
				end
			end
			CMD_MOVE: begin
				if (left && ticks_left != '0) begin
					dx = (x >= anchor_x) ? x - anchor_x : anchor_x - x;
					dy = (y >= anchor_y) ? y - anchor_y : anchor_y - y;
					r2 = radius * radius;
					if (dx * dx + dy * dy > r2) begin
						ticks_left = '0;
						gesture_phase = PH_IDLE;
						r.verdict = V_CANCEL;
					end
				end
			end
			CMD_RELEASE: begin
				if (left && ticks_left != '0) begin
					ticks_left = '0;
					gesture_phase = PH_IDLE;
					r.verdict = V_CANCEL;
				end
			end
			default: begin
				// Tick: count down and act on expiry
				if (ticks_left != '0) begin
					ticks_left = ticks_left - 1'b1;
					if (ticks_left == '0) begin
						if (gesture_phase == PH_WAITING) begin
							ticks_left = (hold_cfg > trigger_cfg) ?
								tick_t'(hold_cfg - trigger_cfg) : tick_t'(1);
							gesture_phase = PH_STARTED;
							r.verdict = V_TRIGGER;
						end else if (gesture_phase == PH_STARTED) begin
							gesture_phase = PH_IDLE;
							r.verdict = V_FINISH;
						end else begin
							gesture_phase = PH_IDLE;
						end
					end
				end
			end
		endcase
		r.hot_x = anchor_x;
		r.hot_y = anchor_y;
		return r;
	endfunction

	// Track register writes, predict accepted words and check result words
	always @(posedge clk or negedge arst_n) begin
		gesture_result_t want;
		if (!arst_n) begin
			radius = TAP_RADIUS_RST;
			trigger_cfg = TRIGGER_TICKS_RST;
			hold_cfg = HOLD_TICKS_RST;
			gesture_phase = PH_IDLE;
			ticks_left = '0;
			anchor_x = '0;
			anchor_y = '0;
			predicted_results.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TAP_RADIUS:    radius = cfg_data[RADIUS_BITS-1:0];
					REG_TRIGGER_TICKS: trigger_cfg = cfg_data;
					REG_HOLD_TICKS:    hold_cfg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				predicted_results.push_back(classify_event(cmd_t'(cmd), left_button, x_pos,
					y_pos));
			end
			if (out_valid && !out_stall) begin
				if (predicted_results.size() == 0) begin
					mismatches++;
					$display("%0t: result word with none expected, got verdict %0d at %0d,%0d",
						$time, verdict, hot_x, hot_y);
				end else begin
					want = predicted_results.pop_front();
					if (verdict !== want.verdict) begin
						mismatches++;
						$display("%0t: verdict expected %0d, got %0d", $time, want.verdict,
							verdict);
					end
					if (hot_x !== want.hot_x) begin
						mismatches++;
						$display("%0t: hot_x expected %0d, got %0d", $time, want.hot_x, hot_x);
					end
					if (hot_y !== want.hot_y) begin
						mismatches++;
						$display("%0t: hot_y expected %0d, got %0d", $time, want.hot_y, hot_y);
					end
				end
			end
			outstanding <= predicted_results.size();
		end
	end

endmodule

### verif/testbench.sv
// Top of the tap-and-hold detector testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
	import thd_pkg::*;

	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int HOLD_OFF_CYCLES = 300;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [1:0] cmd;
	logic       left_button;
	coord_t     x_pos;
	coord_t     y_pos;
	logic       out_valid;
	logic       out_stall;
	logic [2:0] verdict;
	coord_t     hot_x;
	coord_t     hot_y;
	logic       cfg_valid;
	logic       cfg_ready;
	cfg_index_t cfg_index;
	cfg_data_t  cfg_data;

	int mismatches;
	int outstanding;
	int quiet_cycles = 0;
	int events_sent = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_off_requests = 0;

	// Register values as last written, used to shape the gestures
	int cur_radius = TAP_RADIUS_RST;
	int cur_trigger = TRIGGER_TICKS_RST;
	int cur_hold = HOLD_TICKS_RST;

	tap_and_hold_detector_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.left_button (left_button),
		.x_pos       (x_pos),
		.y_pos       (y_pos),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.verdict     (verdict),
		.hot_x       (hot_x),
		.hot_y       (hot_y),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	tap_and_hold_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.left_button (left_button),
		.x_pos       (x_pos),
		.y_pos       (y_pos),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.verdict     (verdict),
		.hot_x       (hot_x),
		.hot_y       (hot_y),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Abort when no word moves on any channel for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Result side: random stalls, plus a long hold-off whenever one is requested
	initial begin
		int served;
		served = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_requests > served) begin
				served++;
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Offer one event word, with random idle cycles first, and wait until it is taken
	task automatic send_event(cmd_t kind, logic left, coord_t x, coord_t y);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= kind;
		left_button <= left;
		x_pos <= x;
		y_pos <= y;
		do @(posedge clk); while (in_stall);
		events_sent++;
	endtask

	// Drop valid and wait until every predicted result word has arrived
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_register(cfg_index_t idx, cfg_data_t value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_settings(int radius, int trigger, int hold);
		write_register(REG_TAP_RADIUS, cfg_data_t'(radius));
		write_register(REG_TRIGGER_TICKS, cfg_data_t'(trigger));
		write_register(REG_HOLD_TICKS, cfg_data_t'(hold));
		cfg_valid <= 1'b0;
		cur_radius = radius;
		cur_trigger = trigger;
		cur_hold = hold;
	endtask

	// Random coordinate over the whole touch range
	function automatic coord_t rand_coord();
		return coord_t'($urandom_range(4095));
	endfunction

	// Random button bit
	function automatic logic rand_bit();
		return 1'($urandom_range(1));
	endfunction

	// Point near the press point, straddling the radius boundary
	function automatic coord_t nudge(coord_t base);
		int reach;
		int pos;
		reach = cur_radius + cur_radius / 2 + 1;
		pos = int'(base) + int'($urandom_range(2 * reach)) - reach;
		if (pos < 0)
			pos = 0;
		if (pos > 4095)
			pos = 4095;
		return coord_t'(pos);
	endfunction

	task automatic send_noise();
		send_event(cmd_t'($urandom_range(3)), rand_bit(), rand_coord(), rand_coord());
	endtask

	// Mostly well-formed gestures with random content, some noise and broken sequences
	task automatic run_gestures(int budget);
		int first;
		int span;
		int pick;
		coord_t px;
		coord_t py;
		first = events_sent;
		span = (cur_trigger > cur_hold) ? cur_trigger : cur_hold;
		if (span > 600)
			span = 40;
		if (span < 1)
			span = 1;
		while (events_sent - first < budget) begin
			if ($urandom_range(9) == 0) begin
				repeat ($urandom_range(1, 4)) send_noise();
			end else begin
				px = rand_coord();
				py = rand_coord();
				send_event(CMD_PRESS, 1'b1, px, py);
				repeat ($urandom_range(1, 12)) begin
					pick = $urandom_range(99);
					if (pick < 55) begin
						repeat ($urandom_range(1, span / 3 + 1))
							send_event(CMD_TICK, rand_bit(), rand_coord(), rand_coord());
					end else if (pick < 75) begin
						send_event(CMD_MOVE, 1'b1, nudge(px), nudge(py));
					end else if (pick < 80) begin
						send_event(CMD_MOVE, 1'b1, rand_coord(), rand_coord());
					end else if (pick < 85) begin
						send_event(CMD_MOVE, 1'b0, rand_coord(), rand_coord());
					end else if (pick < 90) begin
						send_event(CMD_RELEASE, 1'b1, rand_coord(), rand_coord());
					end else if (pick < 93) begin
						send_event($urandom_range(1) ? CMD_PRESS : CMD_RELEASE, 1'b0,
							rand_coord(), rand_coord());
					end else if (pick < 97) begin
						// restart from a fresh point
						px = rand_coord();
						py = rand_coord();
						send_event(CMD_PRESS, 1'b1, px, py);
					end else begin
						send_noise();
					end
				end
				// run the countdown out to the end now and then, unless the span was capped at 40
				if ($urandom_range(1))
					repeat (span + 1) send_event(CMD_TICK, 1'b0, 12'd0, 12'd0);
			end
		end
	endtask

	task automatic run_phase(int radius, int trigger, int hold, int idle, int stall,
			int budget, bit squeeze);
		wait_idle();
		load_settings(radius, trigger, hold);
		send_idle_pct = idle;
		stall_pct = stall;
		if (squeeze)
			hold_off_requests <= hold_off_requests + 1;
		run_gestures(budget);
	endtask

	// Stimulus
	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		cmd <= CMD_PRESS;
		left_button <= 1'b0;
		x_pos <= '0;
		y_pos <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_TAP_RADIUS;
		cfg_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Events with no gesture running are ignored
		send_event(CMD_TICK, 1'b1, 12'd4095, 12'd4095);
		send_event(CMD_MOVE, 1'b1, 12'd4095, 12'd0);
		send_event(CMD_RELEASE, 1'b1, 12'd0, 12'd4095);
		send_event(CMD_PRESS, 1'b0, 12'd4095, 12'd4095);
		// Press at a corner, cancel by moving to the opposite one
		send_event(CMD_PRESS, 1'b1, 12'd4095, 12'd4095);
		send_event(CMD_MOVE, 1'b1, 12'd0, 12'd0);
		// Exactly on the radius holds, just beyond it cancels
		send_event(CMD_PRESS, 1'b1, 12'd0, 12'd0);
		send_event(CMD_MOVE, 1'b1, 12'd16, 12'd0);
		send_event(CMD_MOVE, 1'b1, 12'd11, 12'd12);
		// Non-left move and release are ignored while running
		send_event(CMD_PRESS, 1'b1, 12'd2048, 12'd0);
		send_event(CMD_MOVE, 1'b0, 12'd0, 12'd4095);
		send_event(CMD_RELEASE, 1'b0, 12'd0, 12'd0);
		// Press again restarts, left release cancels, a second release is ignored
		send_event(CMD_PRESS, 1'b1, 12'd100, 12'd4095);
		send_event(CMD_RELEASE, 1'b1, 12'd0, 12'd0);
		send_event(CMD_RELEASE, 1'b1, 12'd0, 12'd0);

		// Shortest trigger and finish
		wait_idle();
		load_settings(16, 1, 2);
		send_event(CMD_PRESS, 1'b1, 12'd5, 12'd6);
		send_event(CMD_TICK, 1'b1, 12'd4095, 12'd4095);
		send_event(CMD_TICK, 1'b0, 12'd0, 12'd0);
		send_event(CMD_TICK, 1'b0, 12'd0, 12'd0);
		send_event(CMD_MOVE, 1'b1, 12'd4095, 12'd4095);

		// Random phases; the first runs at the reset settings
		run_phase(TAP_RADIUS_RST, TRIGGER_TICKS_RST, HOLD_TICKS_RST, 0, 0, 300, 1'b0);
		run_phase(1023, 1, 1, 82, 0, 220, 1'b0);
		run_phase(0, 0, 3, 0, 82, 220, 1'b0);
		run_phase(5, 3, 9, 24, 24, 220, 1'b0);
		run_phase(40, 65535, 65535, 0, 0, 120, 1'b0);
		run_phase(12, 4, 2, 0, 82, 220, 1'b0);
		run_phase(16, 2, 6, 0, 24, 220, 1'b1);

		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
